### rtl/core/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg: shared definitions for the piecewise linear curve core
// Widths, command and register codes, stage records, the segment width table
// and the one-bit restoring division step used by both divider pipelines.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 5;
    localparam int VAL_W      = 32;
    localparam int POS_W      = 16;
    localparam int W_W        = 10;               // segment width, up to 1000
    localparam int DIFF_W     = VAL_W + 1;
    localparam int PROD_W     = DIFF_W + POS_W;
    localparam int MAG_W      = PROD_W - 1;
    localparam int SUM_W      = PROD_W + 1;

    localparam int DIV_STEPS  = 4;                // quotient bits per stage
    localparam int SEG_STAGES = POS_W / DIV_STEPS;
    localparam int QUO_STAGES = MAG_W / DIV_STEPS;
    localparam int WRITE_LAT  = SEG_STAGES + 2;
    localparam int LATENCY    = SEG_STAGES + QUO_STAGES + 8;

    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic REG_POINT_COUNT = 1'b0;      // word index of point_count
    localparam logic CMD_WRITE       = 1'b0;
    localparam logic CMD_EVAL        = 1'b1;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_DIRECT,
        MODE_INTERP
    } t_mode;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
    } t_front;

    typedef struct packed {
        t_mode            mode;
        logic [VAL_W-1:0] p0;
        logic             neg;
    } t_tail;

    // 1000 / (count - 1) for every usable point count
    function automatic logic [W_W-1:0] seg_width(input logic [CNT_W-1:0] qty);
        logic [W_W-1:0] w;
        case (qty)
            5'd2:    w = 10'd1000;
            5'd3:    w = 10'd500;
            5'd4:    w = 10'd333;
            5'd5:    w = 10'd250;
            5'd6:    w = 10'd200;
            5'd7:    w = 10'd166;
            5'd8:    w = 10'd142;
            5'd9:    w = 10'd125;
            5'd10:   w = 10'd111;
            5'd11:   w = 10'd100;
            5'd12:   w = 10'd90;
            5'd13:   w = 10'd83;
            5'd14:   w = 10'd76;
            5'd15:   w = 10'd71;
            5'd16:   w = 10'd66;
            default: w = 10'd1;
        endcase
        return w;
    endfunction

    // one restoring step: {quotient bit, new partial remainder}
    function automatic logic [W_W:0] div_step(input logic [W_W-1:0] rem,
                                              input logic           din,
                                              input logic [W_W-1:0] w);
        logic [W_W:0] t;
        logic [W_W:0] d;
        t = {rem, din};
        d = t - {1'b0, w};
        if (t >= {1'b0, w}) begin
            return {1'b1, d[W_W-1:0]};
        end
        return {1'b0, t[W_W-1:0]};
    endfunction

endpackage

### rtl/core/plc_ram.sv
// ----------------------------------------------------------------------------
// plc_ram: generic RAM, one write port, two registered read ports
// Read data shows the contents before a write at the same edge.
// ----------------------------------------------------------------------------
module plc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/core/piecewise_linear_curve_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_curve_core: evaluate a curve of evenly spaced points
// Up to 16 points over a span of 0 to 1000; linear interpolation between them.
// ----------------------------------------------------------------------------
// The core takes one item per clock and never asserts busy. A write item
// (cmd 0) stores a point and gives no result; an evaluate item (cmd 1) gives
// exactly one result, strobed on o_valid for one cycle, in the order the
// items came in. There is no way to hold a result off, so capture it when
// o_valid is high. The pipeline holds two divider pipelines, each retiring 4
// quotient bits per stage: 4 stages for position / segment width, 12 stages
// for the 48-bit product magnitude / width; the intake, table access, read,
// difference, multiply, magnitude, sign and saturation stages add eight
// more. Writes land in the point table at the same stage where evaluations
// read it, so every evaluation sees exactly the writes taken before it.
// Points read back only after they were written; change point_count only
// when no item is in flight.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [plc_pkg::APB_AW-1:0]   paddr,
    input  logic [plc_pkg::APB_DW-1:0]   pwdata,
    output logic [plc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    // items
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cmd,
    input  logic [plc_pkg::IDX_W-1:0]    i_entry_index,
    input  logic signed [plc_pkg::VAL_W-1:0] i_entry_value,
    input  logic signed [plc_pkg::POS_W-1:0] i_position,
    // results
    output logic                         o_valid,
    output logic signed [plc_pkg::VAL_W-1:0] o_curve_value
);

    import plc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration register and derived segment geometry
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_point_count;
    logic             cfg_wr;
    logic [CNT_W-1:0] qty;
    logic [CNT_W-1:0] last_idx;
    logic [W_W-1:0]   seg_w;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[APB_AW-1] == REG_POINT_COUNT);
    assign prdata = (paddr[APB_AW-1] == REG_POINT_COUNT) ?
                    {{(APB_DW-CNT_W){1'b0}}, r_point_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (cfg_wr) begin
            r_point_count <= pwdata[CNT_W-1:0];
        end
    end

    // a count above the table size uses the whole table
    assign qty      = (r_point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                           : r_point_count;
    assign last_idx = qty - 1'b1;
    assign seg_w    = seg_width(qty);

    // ------------------------------------------------------------------
    // Intake: every cycle is open for a new item
    // ------------------------------------------------------------------
    logic   accept;
    logic   r_s1_vld;
    t_front r_s1;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= '{cmd: i_cmd, idx: i_entry_index, value: i_entry_value,
                  pos: i_position};
    end

    // ------------------------------------------------------------------
    // Segment divider: position / segment width, 4 bits per stage.
    // A negative position divides as zero; it clamps to the first segment.
    // ------------------------------------------------------------------
    logic [SEG_STAGES-1:0] r_sd_vld;
    t_front                r_sd_item [SEG_STAGES];
    logic [W_W-1:0]        r_sd_rem  [SEG_STAGES];
    logic [POS_W-1:0]      r_sd_dq   [SEG_STAGES];

    for (genvar k = 0; k < SEG_STAGES; k++) begin : g_sd
        logic           vld_in;
        t_front         item_in;
        logic [W_W-1:0] rem_in;
        logic [POS_W-1:0] dq_in;
        logic [W_W-1:0] n_rem;
        logic [POS_W-1:0] n_dq;
        logic [W_W:0]   st;

        if (k == 0) begin : g_first
            assign vld_in  = r_s1_vld;
            assign item_in = r_s1;
            assign rem_in  = '0;
            assign dq_in   = r_s1.pos[POS_W-1] ? '0 : r_s1.pos;
        end else begin : g_next
            assign vld_in  = r_sd_vld[k-1];
            assign item_in = r_sd_item[k-1];
            assign rem_in  = r_sd_rem[k-1];
            assign dq_in   = r_sd_dq[k-1];
        end

        always_comb begin
            n_rem = rem_in;
            n_dq  = dq_in;
            st    = '0;
            for (int j = 0; j < DIV_STEPS; j++) begin
                st    = div_step(n_rem, n_dq[POS_W-1], seg_w);
                n_rem = st[W_W-1:0];
                n_dq  = {n_dq[POS_W-2:0], st[W_W]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd_vld[k] <= 1'b0;
            end else begin
                r_sd_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sd_item[k] <= item_in;
            r_sd_rem[k]  <= n_rem;
            r_sd_dq[k]   <= n_dq;
        end
    end

    // ------------------------------------------------------------------
    // Table access stage: pick the mode and the points to read, or write
    // ------------------------------------------------------------------
    t_front           m_item;
    logic [POS_W-1:0] seg_q;
    logic [W_W-1:0]   seg_r;
    t_mode            n_m_mode;
    logic [IDX_W-1:0] n_m_a0;
    logic [IDX_W-1:0] n_m_a1;
    logic [POS_W-1:0] n_m_rem;

    assign m_item = r_sd_item[SEG_STAGES-1];
    assign seg_q  = r_sd_dq[SEG_STAGES-1];
    assign seg_r  = r_sd_rem[SEG_STAGES-1];

    always_comb begin
        n_m_mode = MODE_INTERP;
        n_m_a0   = seg_q[IDX_W-1:0];
        n_m_a1   = seg_q[IDX_W-1:0] + 1'b1;
        if (qty == '0) begin
            n_m_mode = MODE_ZERO;
        end else if (qty == CNT_W'(1)) begin
            // a single point is the whole curve
            n_m_mode = MODE_DIRECT;
            n_m_a0   = '0;
        end else if (seg_q >= POS_W'(last_idx)) begin
            // at or past the last point: hold the last point
            n_m_mode = MODE_DIRECT;
            n_m_a0   = last_idx[IDX_W-1:0];
        end
        // below the span the offset is the position itself (extrapolate)
        n_m_rem = m_item.pos[POS_W-1] ? m_item.pos : {{(POS_W-W_W){1'b0}}, seg_r};
    end

    logic             r_m_vld;
    logic             r_m_cmd;
    logic [IDX_W-1:0] r_m_idx;
    logic [VAL_W-1:0] r_m_value;
    t_mode            r_m_mode;
    logic [POS_W-1:0] r_m_rem;
    logic [IDX_W-1:0] r_m_a0;
    logic [IDX_W-1:0] r_m_a1;

    always_ff @(posedge i_clk) begin
        r_m_cmd   <= m_item.cmd;
        r_m_idx   <= m_item.idx;
        r_m_value <= m_item.value;
        r_m_mode  <= n_m_mode;
        r_m_rem   <= n_m_rem;
        r_m_a0    <= n_m_a0;
        r_m_a1    <= n_m_a1;
    end

    logic             ram_we;
    logic [VAL_W-1:0] ram_p0;
    logic [VAL_W-1:0] ram_p1;

    assign ram_we = r_m_vld && (r_m_cmd == CMD_WRITE);

    plc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_POINTS)
    ) u_points (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_m_idx),
        .i_wdata   (r_m_value),
        .i_raddr_a (r_m_a0),
        .i_raddr_b (r_m_a1),
        .o_rdata_a (ram_p0),
        .o_rdata_b (ram_p1)
    );

    // ------------------------------------------------------------------
    // Read, difference, multiply and magnitude stages
    // ------------------------------------------------------------------
    logic                     r_r_vld;
    t_mode                    r_r_mode;
    logic signed [POS_W-1:0]  r_r_rem;

    logic                     r_x_vld;
    t_mode                    r_x_mode;
    logic signed [POS_W-1:0]  r_x_rem;
    logic [VAL_W-1:0]         r_x_p0;
    logic signed [DIFF_W-1:0] r_x_diff;

    logic                     r_p_vld;
    t_mode                    r_p_mode;
    logic [VAL_W-1:0]         r_p_p0;
    logic signed [PROD_W-1:0] r_p_prod;

    logic signed [PROD_W-1:0] abs_prod;
    logic                     r_a_vld;
    t_tail                    r_a;
    logic [MAG_W-1:0]         r_a_mag;

    assign abs_prod = r_p_prod[PROD_W-1] ? -r_p_prod : r_p_prod;

    always_ff @(posedge i_clk) begin
        r_r_mode <= r_m_mode;
        r_r_rem  <= r_m_rem;

        r_x_mode <= r_r_mode;
        r_x_rem  <= r_r_rem;
        r_x_p0   <= ram_p0;
        r_x_diff <= $signed({ram_p1[VAL_W-1], ram_p1}) - $signed({ram_p0[VAL_W-1], ram_p0});

        r_p_mode <= r_x_mode;
        r_p_p0   <= r_x_p0;
        r_p_prod <= r_x_diff * r_x_rem;

        r_a      <= '{mode: r_p_mode, p0: r_p_p0, neg: r_p_prod[PROD_W-1]};
        r_a_mag  <= abs_prod[MAG_W-1:0];
    end

    // ------------------------------------------------------------------
    // Quotient divider: |diff * offset| / segment width, 4 bits per stage.
    // Dividing the magnitude and restoring the sign truncates toward zero.
    // ------------------------------------------------------------------
    logic [QUO_STAGES-1:0] r_qd_vld;
    t_tail                 r_qd_side [QUO_STAGES];
    logic [W_W-1:0]        r_qd_rem  [QUO_STAGES];
    logic [MAG_W-1:0]      r_qd_dq   [QUO_STAGES];

    for (genvar k = 0; k < QUO_STAGES; k++) begin : g_qd
        logic             vld_in;
        t_tail            side_in;
        logic [W_W-1:0]   rem_in;
        logic [MAG_W-1:0] dq_in;
        logic [W_W-1:0]   n_rem;
        logic [MAG_W-1:0] n_dq;
        logic [W_W:0]     st;

        if (k == 0) begin : g_first
            assign vld_in  = r_a_vld;
            assign side_in = r_a;
            assign rem_in  = '0;
            assign dq_in   = r_a_mag;
        end else begin : g_next
            assign vld_in  = r_qd_vld[k-1];
            assign side_in = r_qd_side[k-1];
            assign rem_in  = r_qd_rem[k-1];
            assign dq_in   = r_qd_dq[k-1];
        end

        always_comb begin
            n_rem = rem_in;
            n_dq  = dq_in;
            st    = '0;
            for (int j = 0; j < DIV_STEPS; j++) begin
                st    = div_step(n_rem, n_dq[MAG_W-1], seg_w);
                n_rem = st[W_W-1:0];
                n_dq  = {n_dq[MAG_W-2:0], st[W_W]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qd_vld[k] <= 1'b0;
            end else begin
                r_qd_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_qd_side[k] <= side_in;
            r_qd_rem[k]  <= n_rem;
            r_qd_dq[k]   <= n_dq;
        end
    end

    // ------------------------------------------------------------------
    // Sign restore, then add the start point, saturate and select
    // ------------------------------------------------------------------
    t_tail             f_side;
    logic [PROD_W-1:0] quo_ext;
    logic              r_f_vld;
    t_tail             r_f_side;
    logic [PROD_W-1:0] r_f_q;

    assign f_side  = r_qd_side[QUO_STAGES-1];
    assign quo_ext = {1'b0, r_qd_dq[QUO_STAGES-1]};

    always_ff @(posedge i_clk) begin
        r_f_side <= f_side;
        r_f_q    <= f_side.neg ? -quo_ext : quo_ext;
    end

    logic [SUM_W-1:0] sum;
    logic [VAL_W-1:0] sat_sum;
    logic [VAL_W-1:0] n_o_value;
    logic             r_o_vld;
    logic [VAL_W-1:0] r_o_value;

    assign sum = {{(SUM_W-VAL_W){r_f_side.p0[VAL_W-1]}}, r_f_side.p0} +
                 {r_f_q[PROD_W-1], r_f_q};

    always_comb begin
        sat_sum = sum[VAL_W-1:0];
        if (!sum[SUM_W-1] && (|sum[SUM_W-2:VAL_W-1])) begin
            sat_sum = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:VAL_W-1])) begin
            sat_sum = {1'b1, {(VAL_W-1){1'b0}}};
        end
        case (r_f_side.mode)
            MODE_ZERO:   n_o_value = '0;
            MODE_DIRECT: n_o_value = r_f_side.p0;
            MODE_INTERP: n_o_value = sat_sum;
            default:     n_o_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_o_value <= n_o_value;
    end

    // valid bits of the fixed stages; write items drop after the table stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_r_vld <= 1'b0;
            r_x_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_a_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_m_vld <= r_sd_vld[SEG_STAGES-1];
            r_r_vld <= r_m_vld && (r_m_cmd == CMD_EVAL);
            r_x_vld <= r_r_vld;
            r_p_vld <= r_x_vld;
            r_a_vld <= r_p_vld;
            r_f_vld <= r_qd_vld[QUO_STAGES-1];
            r_o_vld <= r_f_vld;
        end
    end

    assign o_valid       = r_o_vld;
    assign o_curve_value = r_o_value;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_eval_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == CMD_EVAL)) |-> ##LATENCY o_valid)
        else $error("evaluate item lost in the pipeline");

    a_result_has_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && (i_cmd == CMD_EVAL), LATENCY))
        else $error("result without a matching evaluate item");

    a_write_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> $past(start && !busy && (i_cmd == CMD_WRITE), WRITE_LAT))
        else $error("table write without a matching write item");

endmodule
